[hw/rtl/cupc_pkg.sv]
package cupc_pkg;

    localparam int WINDOW_DEPTH_DEF = 128;

    localparam int USAGE_W   = 7;
    localparam int KIND_W    = 3;
    localparam int CONF_W    = 7;
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int LAG_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL  = 1'b1;

    localparam logic [USAGE_W-1:0] BURST_LEVEL_RST = 7'd70;
    localparam logic [USAGE_W-1:0] IDLE_LEVEL_RST  = 7'd10;

    localparam logic [KIND_W-1:0] KIND_STEADY     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BURSTY     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PERIODIC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ASCENDING  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DESCENDING = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IDLE_HEAVY = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CPU_HEAVY  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_IRREGULAR  = 3'd7;

    localparam logic [USAGE_W-1:0] HEAVY_HIGH  = 7'd70;
    localparam logic [USAGE_W-1:0] HEAVY_LOW   = 7'd20;
    localparam logic [USAGE_W-1:0] MATCH_LIMIT = 7'd20;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_MDIV,
        S_VAR,
        S_VDIV,
        S_LSEL,
        S_PER,
        S_PDIV,
        S_TDIV,
        S_DECIDE,
        S_PRED,
        S_DONE
    } t_state;

    function automatic logic [LAG_W-1:0] lag_of(input logic [2:0] idx);
        logic [LAG_W-1:0] lag;
        unique case (idx)
            3'd0: lag = 5'd2;
            3'd1: lag = 5'd3;
            3'd2: lag = 5'd4;
            3'd3: lag = 5'd5;
            3'd4: lag = 5'd8;
            3'd5: lag = 5'd10;
            3'd6: lag = 5'd16;
            3'd7: lag = 5'd20;
            default: lag = 5'd2;
        endcase
        return lag;
    endfunction

endpackage

[hw/rtl/cupc_div.sv]
module cupc_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

[hw/rtl/cpu_usage_pattern_classifier_core.sv]
// Classifies CPU usage over a sliding window of the last WINDOW_DEPTH samples as steady,
// bursty, periodic, ascending, descending, idle-heavy, cpu-heavy or irregular, and predicts
// the next pattern. One sample is taken at a time through the usage channel, and one result
// follows each sample. The window is walked once for the sum and counts, once for the
// variance and, once the fill n reaches twenty, once for each lag below half of n, reading
// one or two samples a cycle from the window memory, and a shared bit-serial divider forms
// the mean, the variance, each match rate and the trend. While fewer than ten samples are
// held, only the first walk is made. A new sample is taken while the previous result still
// waits on the result channel. Configuration writes are always taken and should only be
// made while the block is idle.
module cpu_usage_pattern_classifier_core #(
    parameter int WINDOW_DEPTH = cupc_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cupc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cupc_pkg::USAGE_W-1:0]   i_cfg_data,
    input  logic                           i_usage_valid,
    output logic                           o_usage_ready,
    input  logic [cupc_pkg::USAGE_W-1:0]   i_usage,
    output logic                           o_result_valid,
    input  logic                           i_result_ready,
    output logic [cupc_pkg::KIND_W-1:0]    o_current_kind,
    output logic [cupc_pkg::CONF_W-1:0]    o_current_confidence,
    output logic                           o_kind_changed,
    output logic [cupc_pkg::KIND_W-1:0]    o_predicted_kind,
    output logic [cupc_pkg::CONF_W-1:0]    o_predicted_confidence,
    output logic [cupc_pkg::TOTAL_W-1:0]   o_change_total
);

    import cupc_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int N_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = N_W + USAGE_W;
    localparam int DVD_W = N_W + 2 * USAGE_W;

    t_state r_state;
    t_state n_state;

    logic [USAGE_W-1:0] r_mem [WINDOW_DEPTH];
    logic [USAGE_W-1:0] r_da;
    logic [USAGE_W-1:0] r_db;

    logic [USAGE_W-1:0] r_burst_level;
    logic [USAGE_W-1:0] r_idle_level;
    logic [AW-1:0]      r_slot;
    logic [N_W-1:0]     r_n;
    logic [N_W-1:0]     r_k;
    logic               r_rv;
    logic               r_rf;

    logic [SUM_W-1:0]   r_sum;
    logic [N_W-1:0]     r_high;
    logic [N_W-1:0]     r_low;
    logic [N_W-1:0]     r_trans;
    logic               r_inside;
    logic               r_fb;
    logic               r_fi;
    logic [USAGE_W-1:0] r_x0;
    logic [USAGE_W-1:0] r_xl;
    logic [USAGE_W-1:0] r_mean;
    logic [DVD_W-1:0]   r_vacc;
    logic [CONF_W-1:0]  r_steady;
    logic [3:0]         r_li;
    logic [N_W-1:0]     r_hits;
    logic [CONF_W-1:0]  r_best;
    logic [USAGE_W-1:0] r_tmag;

    logic [KIND_W-1:0]  r_held;
    logic [CONF_W-1:0]  r_conf;
    logic [TOTAL_W-1:0] r_chg;
    logic [TOTAL_W-1:0] r_occ [8];
    logic               r_changed;
    logic [2:0]         r_pi;
    logic [TOTAL_W-1:0] r_top;
    logic [KIND_W-1:0]  r_pred;
    logic               r_ov;

    logic               w_accept;
    logic               w_issue;
    logic               w_pass_end;
    logic               w_long;
    logic               w_lag_ok;
    logic               w_load;
    logic [LAG_W-1:0]   w_lag;
    logic [N_W-1:0]     w_kb;
    logic [AW-1:0]      w_addr_a;
    logic [AW-1:0]      w_addr_b;
    logic               w_div_start;
    logic [DVD_W-1:0]   w_div_dvd;
    logic [N_W-1:0]     w_div_dvs;
    logic               w_div_done;
    logic [DVD_W-1:0]   w_div_q;
    logic [USAGE_W-1:0] w_d;
    logic [USAGE_W-1:0] w_ab;
    logic [USAGE_W-1:0] w_tabs;
    logic               w_tneg;
    logic [CONF_W-1:0]  w_win_conf;
    logic [KIND_W-1:0]  w_win_kind;
    logic [CONF_W-1:0]  w_sc_burst;
    logic [CONF_W-1:0]  w_sc_per;
    logic [CONF_W-1:0]  w_sc_trend;
    logic [N_W+1:0]     w_three_q;
    logic               w_update;

    assign w_accept    = i_usage_valid && o_usage_ready;
    assign o_cfg_ready = 1'b1;
    assign w_long      = r_n >= N_W'(10);
    assign w_lag       = lag_of(r_li[2:0]);
    assign w_lag_ok    = (r_n >= N_W'(20)) && (N_W'(w_lag) < (r_n >> 1));
    assign w_kb        = r_k - N_W'(w_lag);
    assign w_pass_end  = (r_k == r_n) && !r_rv;
    assign w_load      = (r_state == S_DONE) && (!r_ov || i_result_ready);

    function automatic logic [AW-1:0] phys(input logic [N_W-1:0] k, input logic [AW-1:0] slot,
                                           input logic full);
        logic [N_W:0] s;
        s = (N_W+1)'(slot) + (N_W+1)'(k);
        if (s >= (N_W+1)'(WINDOW_DEPTH)) begin
            s = s - (N_W+1)'(WINDOW_DEPTH);
        end
        return full ? s[AW-1:0] : k[AW-1:0];
    endfunction

    assign w_addr_a = phys(r_k, r_slot, r_n == N_W'(WINDOW_DEPTH));
    assign w_addr_b = phys(w_kb, r_slot, r_n == N_W'(WINDOW_DEPTH));

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_slot] <= i_usage;
        end
        r_da <= r_mem[w_addr_a];
        r_db <= r_mem[w_addr_b];
    end

    assign w_tneg = r_xl < r_x0;
    assign w_tabs = w_tneg ? (r_x0 - r_xl) : (r_xl - r_x0);
    assign w_d    = (r_da > r_mean) ? (r_da - r_mean) : (r_mean - r_da);
    assign w_ab   = (r_da > r_db) ? (r_da - r_db) : (r_db - r_da);

    cupc_div #(
        .DVD_W(DVD_W),
        .DVS_W(N_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   if (w_pass_end) n_state = w_long ? S_MDIV : S_DECIDE;
            S_MDIV:   if (w_div_done) n_state = S_VAR;
            S_VAR:    if (w_pass_end) n_state = S_VDIV;
            S_VDIV:   if (w_div_done) n_state = S_LSEL;
            S_LSEL: begin
                if (r_li[3]) begin
                    n_state = S_TDIV;
                end else if (w_lag_ok) begin
                    n_state = S_PER;
                end
            end
            S_PER:    if (w_pass_end) n_state = S_PDIV;
            S_PDIV:   if (w_div_done) n_state = S_LSEL;
            S_TDIV:   if (w_div_done) n_state = S_DECIDE;
            S_DECIDE: n_state = S_PRED;
            S_PRED:   if (r_pi == 3'd7) n_state = S_DONE;
            S_DONE:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_usage_ready = r_state == S_IDLE;
        w_issue       = 1'b0;
        w_div_start   = 1'b0;
        w_div_dvd     = '0;
        w_div_dvs     = r_n;
        unique case (r_state)
            S_SCAN: begin
                w_issue     = r_k < r_n;
                w_div_start = w_pass_end && w_long;
                w_div_dvd   = DVD_W'(r_sum);
            end
            S_VAR: begin
                w_issue     = r_k < r_n;
                w_div_start = w_pass_end;
                w_div_dvd   = r_vacc;
            end
            S_LSEL: begin
                w_div_start = r_li[3];
                w_div_dvd   = DVD_W'(w_tabs);
                w_div_dvs   = r_n - 1'b1;
            end
            S_PER: begin
                w_issue     = r_k < r_n;
                w_div_start = w_pass_end;
                w_div_dvd   = DVD_W'(r_hits) * DVD_W'(100);
                w_div_dvs   = r_n - N_W'(w_lag);
            end
            default: begin
                w_issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (r_trans > (r_n >> 2)) begin
            w_sc_burst = (r_trans >= N_W'(10)) ? 7'd95 : 7'(r_trans[3:0]) * 7'd10;
        end else if (r_fb && r_fi) begin
            w_sc_burst = 7'd60;
        end else begin
            w_sc_burst = 7'd0;
        end
        priority if (r_best > 7'd80) w_sc_per = 7'd90;
        else if (r_best > 7'd60) w_sc_per = 7'd70;
        else if (r_best > 7'd40) w_sc_per = 7'd50;
        else w_sc_per = 7'd0;
        if (r_tmag > 7'd2) begin
            w_sc_trend = (r_tmag >= 7'd9) ? 7'd90 : 7'(r_tmag[3:0]) * 7'd10;
        end else begin
            w_sc_trend = 7'd0;
        end

        w_win_conf = 7'd0;
        w_win_kind = KIND_IRREGULAR;
        if (w_long) begin
            if (r_steady > w_win_conf) begin
                w_win_conf = r_steady;
                w_win_kind = KIND_STEADY;
            end
            if (w_sc_burst > w_win_conf) begin
                w_win_conf = w_sc_burst;
                w_win_kind = KIND_BURSTY;
            end
            if (w_sc_per > w_win_conf) begin
                w_win_conf = w_sc_per;
                w_win_kind = KIND_PERIODIC;
            end
            if (w_sc_trend > w_win_conf) begin
                w_win_conf = w_sc_trend;
                w_win_kind = w_tneg ? KIND_DESCENDING : KIND_ASCENDING;
            end
        end
        w_three_q = ((N_W+2)'(r_n) + ((N_W+2)'(r_n) << 1)) >> 2;
        priority if ((N_W+2)'(r_high) > w_three_q) begin
            w_win_conf = 7'd85;
            w_win_kind = KIND_CPU_HEAVY;
        end else if ((N_W+2)'(r_low) > w_three_q) begin
            w_win_conf = 7'd85;
            w_win_kind = KIND_IDLE_HEAVY;
        end
        w_update = (w_win_conf > 7'd60) && (w_win_kind != r_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_burst_level <= BURST_LEVEL_RST;
            r_idle_level  <= IDLE_LEVEL_RST;
            r_slot        <= '0;
            r_n           <= '0;
            r_rv          <= 1'b0;
            r_held        <= KIND_IRREGULAR;
            r_conf        <= '0;
            r_chg         <= '0;
            r_ov          <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_occ[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_rv    <= w_issue;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BURST_LEVEL: r_burst_level <= i_cfg_data;
                    CFG_IDLE_LEVEL:  r_idle_level  <= i_cfg_data;
                    default:         r_idle_level  <= r_idle_level;
                endcase
            end
            if (w_accept) begin
                r_slot <= (r_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                if (r_n != N_W'(WINDOW_DEPTH)) begin
                    r_n <= r_n + 1'b1;
                end
            end
            if (r_state == S_DECIDE && w_update) begin
                r_held <= w_win_kind;
                r_conf <= w_win_conf;
                r_chg  <= r_chg + 1'b1;
                for (int i = 0; i < 8; i++) begin
                    if (w_win_kind == KIND_W'(i)) begin
                        r_occ[i] <= r_occ[i] + 1'b1;
                    end
                end
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_result_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rf <= w_issue && (r_k == '0);
        if (w_issue) begin
            r_k <= r_k + 1'b1;
        end
        if (w_accept) begin
            r_k      <= '0;
            r_sum    <= '0;
            r_high   <= '0;
            r_low    <= '0;
            r_trans  <= '0;
            r_inside <= 1'b0;
            r_fb     <= 1'b0;
            r_fi     <= 1'b0;
            r_best   <= '0;
            r_li     <= '0;
        end
        if (r_rv) begin
            unique case (r_state)
                S_SCAN: begin
                    r_sum <= r_sum + SUM_W'(r_da);
                    r_xl  <= r_da;
                    if (r_rf) begin
                        r_x0 <= r_da;
                    end
                    if (r_da > HEAVY_HIGH) begin
                        r_high <= r_high + 1'b1;
                    end else if (r_da < HEAVY_LOW) begin
                        r_low <= r_low + 1'b1;
                    end
                    if (r_da > r_burst_level) begin
                        r_fb     <= 1'b1;
                        r_inside <= 1'b1;
                        if (!r_inside) begin
                            r_trans <= r_trans + 1'b1;
                        end
                    end else if (r_da < r_idle_level) begin
                        r_fi     <= 1'b1;
                        r_inside <= 1'b0;
                        if (r_inside) begin
                            r_trans <= r_trans + 1'b1;
                        end
                    end
                end
                S_VAR: begin
                    r_vacc <= r_vacc + DVD_W'(w_d) * DVD_W'(w_d);
                end
                S_PER: begin
                    if (w_ab < MATCH_LIMIT) begin
                        r_hits <= r_hits + 1'b1;
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
        unique case (r_state)
            S_MDIV: begin
                if (w_div_done) begin
                    r_mean <= w_div_q[USAGE_W-1:0];
                    r_k    <= '0;
                    r_vacc <= '0;
                end
            end
            S_VDIV: begin
                if (w_div_done) begin
                    priority if (w_div_q < DVD_W'(100)) r_steady <= 7'd90;
                    else if (w_div_q < DVD_W'(300)) r_steady <= 7'd70;
                    else if (w_div_q < DVD_W'(500)) r_steady <= 7'd50;
                    else r_steady <= 7'd0;
                end
            end
            S_LSEL: begin
                if (!r_li[3]) begin
                    if (w_lag_ok) begin
                        r_k    <= N_W'(w_lag);
                        r_hits <= '0;
                    end else begin
                        r_li <= r_li + 1'b1;
                    end
                end
            end
            S_PDIV: begin
                if (w_div_done) begin
                    if (w_div_q[CONF_W-1:0] > r_best) begin
                        r_best <= w_div_q[CONF_W-1:0];
                    end
                    r_li <= r_li + 1'b1;
                end
            end
            S_TDIV: begin
                if (w_div_done) begin
                    r_tmag <= w_div_q[USAGE_W-1:0];
                end
            end
            S_DECIDE: begin
                r_changed <= w_update;
                r_pi      <= '0;
                r_top     <= '0;
                r_pred    <= KIND_IRREGULAR;
            end
            S_PRED: begin
                if (r_occ[r_pi] > r_top) begin
                    r_top  <= r_occ[r_pi];
                    r_pred <= r_pi;
                end
                r_pi <= r_pi + 1'b1;
            end
            default: begin
                r_pi <= r_pi;
            end
        endcase
        if (w_load) begin
            o_current_kind         <= r_held;
            o_current_confidence   <= r_conf;
            o_kind_changed         <= r_changed;
            o_predicted_kind       <= (r_held != KIND_IRREGULAR && r_conf > 7'd80) ?
                                      r_held : r_pred;
            o_predicted_confidence <= (r_top >= TOTAL_W'(9)) ? 7'd90 :
                                      7'(r_top[3:0]) * 7'd10;
            o_change_total         <= r_chg;
        end
    end

    assign o_result_valid = r_ov;

    a_div_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_MDIV || r_state == S_VDIV || r_state == S_PDIV ||
                        r_state == S_TDIV))
        else $error("divider finished outside a divide state");

    a_read_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv |-> (r_state == S_SCAN || r_state == S_VAR || r_state == S_PER))
        else $error("window read data arrived outside a pass");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_W'(WINDOW_DEPTH))
        else $error("fill level beyond window depth");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_result_valid && r_state == S_IDLE))
        else $error("result transfer not presented after completion");

endmodule

[tb/cupc_checker.sv]
module cupc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [cupc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cupc_pkg::USAGE_W-1:0]   i_cfg_data,
    input  logic                           i_usage_valid,
    input  logic                           i_usage_ready,
    input  logic [cupc_pkg::USAGE_W-1:0]   i_usage,
    input  logic                           i_result_valid,
    input  logic                           i_result_ready,
    input  logic [cupc_pkg::KIND_W-1:0]    i_current_kind,
    input  logic [cupc_pkg::CONF_W-1:0]    i_current_confidence,
    input  logic                           i_kind_changed,
    input  logic [cupc_pkg::KIND_W-1:0]    i_predicted_kind,
    input  logic [cupc_pkg::CONF_W-1:0]    i_predicted_confidence,
    input  logic [cupc_pkg::TOTAL_W-1:0]   i_change_total,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import cupc_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [CONF_W-1:0]  conf;
        logic               changed;
        logic [KIND_W-1:0]  pkind;
        logic [CONF_W-1:0]  pconf;
        logic [TOTAL_W-1:0] total;
    } t_verdict;

    t_verdict           verdict_q[$];
    logic [USAGE_W-1:0] samples[DEPTH];
    int unsigned        slot, fill;
    logic [KIND_W-1:0]  cur_kind;
    logic [CONF_W-1:0]  cur_conf;
    logic [31:0]        changes;
    logic [31:0]        seen[8];
    int unsigned        burst_lvl, idle_lvl;

    assign o_pending = verdict_q.size();

    function automatic int unsigned oldest(int unsigned k);
        return (fill < DEPTH) ? samples[k] : samples[(slot + k) % DEPTH];
    endfunction

    function automatic int unsigned steady_score(int unsigned n);
        int unsigned sum, mean, var_acc, x, d;
        sum = 0;
        var_acc = 0;
        if (n < 10) return 0;
        for (int unsigned i = 0; i < n; i++) sum += oldest(i);
        mean = sum / n;
        for (int unsigned i = 0; i < n; i++) begin
            x = oldest(i);
            d = (x > mean) ? x - mean : mean - x;
            var_acc += d * d;
        end
        var_acc = var_acc / n;
        if (var_acc < 100) return 90;
        if (var_acc < 300) return 70;
        if (var_acc < 500) return 50;
        return 0;
    endfunction

    function automatic int unsigned burst_score(int unsigned n);
        int unsigned bursts, idles, trans, x;
        bit bursting;
        bursts = 0;
        idles = 0;
        trans = 0;
        bursting = 0;
        if (n < 10) return 0;
        for (int unsigned i = 0; i < n; i++) begin
            x = oldest(i);
            if (x > burst_lvl) begin
                bursts++;
                if (!bursting) begin
                    trans++;
                    bursting = 1;
                end
            end else if (x < idle_lvl) begin
                idles++;
                if (bursting) begin
                    trans++;
                    bursting = 0;
                end
            end
        end
        if (trans > n / 4) return (trans * 10 < 95) ? trans * 10 : 95;
        if (bursts > 0 && idles > 0) return 60;
        return 0;
    endfunction

    function automatic int unsigned period_score(int unsigned n);
        int unsigned best, lag, hits, cmps, a, b, d, rate;
        best = 0;
        if (n < 20) return 0;
        for (int i = 0; i < 8; i++) begin
            lag = lag_of(3'(i));
            if (lag < n / 2) begin
                hits = 0;
                cmps = 0;
                for (int unsigned j = lag; j < n; j++) begin
                    a = oldest(j);
                    b = oldest(j - lag);
                    d = (a > b) ? a - b : b - a;
                    if (d < 20) hits++;
                    cmps++;
                end
                rate = (hits * 100) / cmps;
                if (rate > best) best = rate;
            end
        end
        if (best > 80) return 90;
        if (best > 60) return 70;
        if (best > 40) return 50;
        return 0;
    endfunction

    task automatic classify(input logic [USAGE_W-1:0] u);
        int unsigned n, best, c, high, low, top, mag, x;
        int total, avg;
        logic [KIND_W-1:0] winner, pred;
        t_verdict v;
        samples[slot] = u;
        slot = (slot + 1) % DEPTH;
        if (fill < DEPTH) fill++;
        n = fill;
        best = 0;
        winner = KIND_IRREGULAR;
        c = steady_score(n);
        if (c > best) begin
            best = c;
            winner = KIND_STEADY;
        end
        c = burst_score(n);
        if (c > best) begin
            best = c;
            winner = KIND_BURSTY;
        end
        c = period_score(n);
        if (c > best) begin
            best = c;
            winner = KIND_PERIODIC;
        end
        if (n >= 10) begin
            total = int'(oldest(n - 1)) - int'(oldest(0));
            avg = total / int'(n - 1);
            mag = (avg < 0) ? -avg : avg;
            if (mag > 2) begin
                c = (mag * 10 < 90) ? mag * 10 : 90;
                if (c > best) begin
                    best = c;
                    winner = (avg > 0) ? KIND_ASCENDING : KIND_DESCENDING;
                end
            end
        end
        high = 0;
        low = 0;
        for (int unsigned i = 0; i < n; i++) begin
            x = oldest(i);
            if (x > 70) high++;
            else if (x < 20) low++;
        end
        if (high > n * 3 / 4) begin
            winner = KIND_CPU_HEAVY;
            best = 85;
        end else if (low > n * 3 / 4) begin
            winner = KIND_IDLE_HEAVY;
            best = 85;
        end
        v.changed = 0;
        if (best > 60 && winner != cur_kind) begin
            cur_kind = winner;
            cur_conf = CONF_W'(best);
            changes++;
            seen[winner]++;
            v.changed = 1;
        end
        top = 0;
        pred = KIND_IRREGULAR;
        for (int i = 0; i < 8; i++) begin
            if (seen[i] > top) begin
                top = seen[i];
                pred = KIND_W'(i);
            end
        end
        if (cur_kind != KIND_IRREGULAR && cur_conf > 80) pred = cur_kind;
        v.kind = cur_kind;
        v.conf = cur_conf;
        v.pkind = pred;
        v.pconf = (top > 9) ? CONF_W'(90) : CONF_W'(top * 10);
        v.total = changes;
        verdict_q.push_back(v);
    endtask

    task automatic compare(input string field, input longint unsigned exp_v,
                           input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
    end

    always @(posedge i_clk) begin
        t_verdict v;
        if (!i_rst_n) begin
            verdict_q.delete();
            slot = 0;
            fill = 0;
            cur_kind = KIND_IRREGULAR;
            cur_conf = 0;
            changes = 0;
            foreach (seen[i]) seen[i] = 0;
            burst_lvl = BURST_LEVEL_RST;
            idle_lvl = IDLE_LEVEL_RST;
        end else begin
            if (i_result_valid && i_result_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    o_errors++;
                end else begin
                    v = verdict_q.pop_front();
                    compare("current_kind", v.kind, i_current_kind);
                    compare("current_confidence", v.conf, i_current_confidence);
                    compare("kind_changed", v.changed, i_kind_changed);
                    compare("predicted_kind", v.pkind, i_predicted_kind);
                    compare("predicted_confidence", v.pconf, i_predicted_confidence);
                    compare("change_total", v.total, i_change_total);
                    o_checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_BURST_LEVEL) burst_lvl = i_cfg_data;
                else if (i_cfg_index == CFG_IDLE_LEVEL) idle_lvl = i_cfg_data;
            end
            if (i_usage_valid && i_usage_ready) classify(i_usage);
        end
    end
endmodule

[tb/testbench.sv]
module testbench;
    import cupc_pkg::*;

    localparam longint LIMIT = 4000000;

    typedef enum int {
        SHAPE_FLAT, SHAPE_RAMP_UP, SHAPE_RAMP_DOWN, SHAPE_SQUARE,
        SHAPE_SPIKES, SHAPE_HIGH, SHAPE_LOW, SHAPE_NOISE
    } t_shape;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [USAGE_W-1:0]     i_cfg_data;
    logic                   i_usage_valid;
    logic                   o_usage_ready;
    logic [USAGE_W-1:0]     i_usage;
    logic                   o_result_valid;
    logic                   i_result_ready;
    logic [KIND_W-1:0]      o_current_kind;
    logic [CONF_W-1:0]      o_current_confidence;
    logic                   o_kind_changed;
    logic [KIND_W-1:0]      o_predicted_kind;
    logic [CONF_W-1:0]      o_predicted_confidence;
    logic [TOTAL_W-1:0]     o_change_total;
    int                     errors, pending, checked;
    int                     tx_idle, rx_idle, sent;
    longint                 cycles;

    cpu_usage_pattern_classifier_core u_dut (.*);

    cupc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_usage_valid(i_usage_valid), .i_usage_ready(o_usage_ready), .i_usage(i_usage),
        .i_result_valid(o_result_valid), .i_result_ready(i_result_ready),
        .i_current_kind(o_current_kind), .i_current_confidence(o_current_confidence),
        .i_kind_changed(o_kind_changed), .i_predicted_kind(o_predicted_kind),
        .i_predicted_confidence(o_predicted_confidence), .i_change_total(o_change_total),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    always @(negedge i_clk) i_result_ready <= ($urandom_range(99) >= rx_idle);

    task automatic send(input int u);
        while ($urandom_range(99) < tx_idle) begin
            i_usage_valid <= 0;
            @(negedge i_clk);
        end
        i_usage_valid <= 1;
        i_usage <= USAGE_W'(u);
        @(posedge i_clk);
        while (!o_usage_ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_usage_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= USAGE_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic send_shape(input t_shape shape, input int len);
        int base, step, per, v;
        base = $urandom_range(100);
        step = $urandom_range(6, 3);
        per = $urandom_range(10, 2);
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_FLAT:      v = base + $urandom_range(4);
                SHAPE_RAMP_UP:   v = (i * step) % 101;
                SHAPE_RAMP_DOWN: v = 100 - (i * step) % 101;
                SHAPE_SQUARE:    v = ((i / per) % 2) ? 90 + $urandom_range(5) : $urandom_range(5);
                SHAPE_SPIKES:    v = ($urandom_range(3) == 0) ? 95 : $urandom_range(8);
                SHAPE_HIGH:      v = $urandom_range(127, 75);
                SHAPE_LOW:       v = $urandom_range(15);
                default:         v = $urandom_range(127);
            endcase
            send(v > 127 ? 127 : v);
        end
    endtask

    initial begin
        int vals[] = '{0, 127, 100, 101, 0, 127, 1, 99, 64, 63};
        int target;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        i_usage_valid = 0;
        i_usage = 0;
        i_result_ready = 0;
        tx_idle = 18;
        rx_idle = 55;
        sent = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        foreach (vals[i]) send(vals[i]);
        for (int i = 0; i < 12; i++) send(10 + i * 7);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 18 : (ph == 1) ? 55 : 0;
            rx_idle = (ph == 0) ? 55 : (ph == 1) ? 18 : 0;
            case (ph)
                0: begin
                    write_reg(CFG_BURST_LEVEL, 0);
                    write_reg(CFG_IDLE_LEVEL, 127);
                end
                1: begin
                    write_reg(CFG_BURST_LEVEL, 127);
                    write_reg(CFG_IDLE_LEVEL, 0);
                end
                default: begin
                    write_reg(CFG_BURST_LEVEL, 70);
                    write_reg(CFG_IDLE_LEVEL, 10);
                end
            endcase
            target = sent + 80;
            while (sent < target) begin
                send_shape(t_shape'($urandom_range(7)), $urandom_range(30, 8));
                if ($urandom_range(9) == 0) begin
                    drain();
                    write_reg(CFG_BURST_LEVEL, $urandom_range(100));
                    write_reg(CFG_IDLE_LEVEL, $urandom_range(100));
                end
            end
            drain();
        end

        i_usage_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d samples and %0d results over three handshake profiles,", sent,
                 checked);
        $display("with threshold settings at both extremes and random values.");
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
